// File: hw/rtl/jpeg_block_offset_roi_crop_macros.svh
// Assertion macros shared by the ROI crop block.
`ifndef JPEG_BLOCK_OFFSET_ROI_CROP_MACROS_SVH
`define JPEG_BLOCK_OFFSET_ROI_CROP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define JROI_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define JROI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/jroi_pkg.sv
// Types, constants and helpers shared by the ROI crop block.
package jroi_pkg;

    // Offset arithmetic width and blocks per MCU (4:4:4)
    localparam int OFFSET_BITS    = 24;
    localparam int BLOCKS_PER_MCU = 3;
    localparam int OFF_W          = OFFSET_BITS;
    localparam logic [1:0] BIM_LAST = 2'(BLOCKS_PER_MCU - 1);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_COLS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_ROWS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_BYTES   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 3'd7;

    // Result kinds
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_COPY = 1'b1;

    // One result word
    typedef struct packed {
        logic        kind;
        logic [31:0] word;
        logic [23:0] src;
        logic [23:0] dst;
        logic [23:0] len;
    } result_t;

    // One queue entry: the results of one input word
    typedef struct packed {
        logic    two;
        logic    done;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
    } crop_size_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Fit an offset into a 24-bit result field
    function automatic logic [23:0] to_f24(input logic [OFF_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[23:0];
    endfunction

endpackage

// File: hw/rtl/jroi_queue.sv
// Short entry queue between the classifying front and the emitting back.
module jroi_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  jroi_pkg::entry_t push_entry,
    input  logic             pop,
    output jroi_pkg::entry_t head,
    output jroi_pkg::qstat_t stat
);

    jroi_pkg::entry_t mem_reg [jroi_pkg::QDEPTH];
    logic [jroi_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jroi_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jroi_pkg::QCNT_W-1:0] count_reg, count_next;

    // Advance pointers, wrapping at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == jroi_pkg::QPTR_W'(jroi_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == jroi_pkg::QPTR_W'(jroi_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == jroi_pkg::QCNT_W'(jroi_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// File: hw/rtl/jroi_front.sv
// Front part: configuration, offset rebuild, ROI classification and result building.
module jroi_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jroi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [23:0]                          cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          s_tdata,
    input  jroi_pkg::qstat_t                     q_stat,
    output logic                                 push,
    output jroi_pkg::entry_t                     push_entry,
    output jroi_pkg::crop_size_t                 crop_size
);

    localparam int W = jroi_pkg::OFF_W;

    // Configuration registers
    logic [15:0] img_w_reg, img_h_reg, roi_left_reg, roi_top_reg;
    logic [15:0] roi_cols_reg, roi_rows_reg;
    logic [23:0] scan_bytes_reg, total_reg;
    logic        settle_reg;

    // Geometry derived from configuration
    logic [13:0] width_mcu_reg, w_end_mcu_reg, h_end_mcu_reg;
    logic [12:0] w_start_reg, h_start_reg;
    logic [15:0] cw_reg, ch_reg;
    logic        pass_reg;

    // Scan state
    logic [23:0] bc_reg, bc_next;
    logic [1:0]  bim_reg, bim_next;
    logic [12:0] col_reg, col_next, row_reg, row_next;
    logic [W-1:0] run_reg, src_reg, src_next, dest_reg, dest_next, prev_reg, prev_next;
    logic        open_reg, open_next;

    logic [16:0] w_end_sum, h_end_sum, w_end_r, h_end_r, wmcu_r;
    logic [15:0] w_end_px, h_end_px, w_base, h_base;

    logic        accept, active, last, in_roi, row_begin, close, open_a, open_b;
    logic        tail, fits, any;
    logic [2:0]  bitoff;
    logic [W-1:0] absoff, len_close, dest_a, src_b, newoff, len_tail, scan_w, diff;
    logic [W-1:0] bit_inc, rel_off, dest_rel;
    logic [13:0] col_inc;
    logic [31:0] packed_word;
    jroi_pkg::result_t r_close, r_word, r_tail, r_done, r_pass, r_pend;

    assign cfg_ready = 1'b1;
    assign s_tready  = !settle_reg && !q_stat.full;
    assign accept    = s_tvalid && s_tready;

    // Write configuration; hold input in the cycle after each write while geometry settles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg      <= 16'd1;
            img_h_reg      <= 16'd1;
            roi_left_reg   <= '0;
            roi_top_reg    <= '0;
            roi_cols_reg   <= 16'd1;
            roi_rows_reg   <= 16'd1;
            scan_bytes_reg <= '0;
            total_reg      <= 24'd1;
            settle_reg     <= 1'b1;
        end else begin
            settle_reg <= cfg_valid;
            if (cfg_valid) begin
                case (cfg_index)
                    jroi_pkg::REG_IMAGE_WIDTH:  img_w_reg      <= cfg_data[15:0];
                    jroi_pkg::REG_IMAGE_HEIGHT: img_h_reg      <= cfg_data[15:0];
                    jroi_pkg::REG_ROI_LEFT:     roi_left_reg   <= cfg_data[15:0];
                    jroi_pkg::REG_ROI_TOP:      roi_top_reg    <= cfg_data[15:0];
                    jroi_pkg::REG_ROI_COLS:     roi_cols_reg   <= cfg_data[15:0];
                    jroi_pkg::REG_ROI_ROWS:     roi_rows_reg   <= cfg_data[15:0];
                    jroi_pkg::REG_SCAN_BYTES:   scan_bytes_reg <= cfg_data;
                    jroi_pkg::REG_TOTAL_BLOCKS: total_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Clamp the ROI to the image and round it out to MCUs
    always_comb begin
        w_end_sum = {1'b0, roi_left_reg} + {1'b0, roi_cols_reg};
        h_end_sum = {1'b0, roi_top_reg} + {1'b0, roi_rows_reg};
        w_end_px  = (w_end_sum > {1'b0, img_w_reg}) ? img_w_reg : w_end_sum[15:0];
        h_end_px  = (h_end_sum > {1'b0, img_h_reg}) ? img_h_reg : h_end_sum[15:0];
        w_end_r   = {1'b0, w_end_px} + 17'd7;
        h_end_r   = {1'b0, h_end_px} + 17'd7;
        wmcu_r    = {1'b0, img_w_reg} + 17'd7;
        w_base    = {roi_left_reg[15:3], 3'b000};
        h_base    = {roi_top_reg[15:3], 3'b000};
    end

    always_ff @(posedge aclk) begin
        width_mcu_reg <= wmcu_r[16:3];
        w_end_mcu_reg <= w_end_r[16:3];
        h_end_mcu_reg <= h_end_r[16:3];
        w_start_reg   <= roi_left_reg[15:3];
        h_start_reg   <= roi_top_reg[15:3];
        cw_reg        <= (w_end_px > w_base) ? w_end_px - w_base : '0;
        ch_reg        <= (h_end_px > h_base) ? h_end_px - h_base : '0;
        pass_reg      <= (roi_left_reg == '0) && (roi_top_reg == '0)
                      && (w_end_px == img_w_reg) && (h_end_px == img_h_reg);
    end

    assign crop_size.width  = cw_reg;
    assign crop_size.height = ch_reg;

    // Classify the word and build its results
    always_comb begin
        bitoff    = s_tdata[2:0];
        active    = (bc_reg < total_reg);
        last      = (({1'b0, bc_reg} + 25'd1) >= {1'b0, total_reg});
        scan_w    = W'(scan_bytes_reg);
        absoff    = run_reg + W'(s_tdata[15:3]);

        in_roi    = (row_reg >= h_start_reg) && ({1'b0, row_reg} < h_end_mcu_reg)
                 && (col_reg >= w_start_reg) && ({1'b0, col_reg} < w_end_mcu_reg);
        row_begin = (col_reg == w_start_reg) && (bim_reg == '0);
        close     = open_reg && (!in_roi || row_begin);

        // Close the open row against this word; share the row-relative offset
        bit_inc   = W'(bitoff != 3'd0);
        rel_off   = absoff - src_reg;
        len_close = rel_off + bit_inc;
        dest_rel  = dest_reg + rel_off;
        dest_a    = close ? dest_rel + bit_inc : dest_reg;
        open_a    = open_reg && !close;
        src_b     = (in_roi && !open_a) ? absoff : src_reg;
        open_b    = open_a || in_roi;

        // Re-pack the delta against the compacted destination
        newoff      = open_a ? dest_rel : dest_a;
        diff        = newoff - prev_reg;
        packed_word = {s_tdata[31:16], diff[12:0], bitoff};
        prev_next   = in_roi ? newoff : prev_reg;

        // Close the last row against the scan end; no row closes on the same word
        tail      = last && open_b;
        fits      = !(close && in_roi);
        len_tail  = scan_w - src_b;
        dest_next = (tail && fits) ? dest_reg + len_tail : dest_a;
        src_next  = src_b;
        open_next = open_b && !last;
        any       = close || in_roi || last;

        r_close = '{kind: jroi_pkg::KIND_COPY, word: '0, src: jroi_pkg::to_f24(src_reg),
                    dst: jroi_pkg::to_f24(dest_reg), len: jroi_pkg::to_f24(len_close)};
        r_word  = '{kind: jroi_pkg::KIND_WORD, word: packed_word, src: '0, dst: '0, len: '0};
        r_tail  = '{kind: jroi_pkg::KIND_COPY, word: '0, src: jroi_pkg::to_f24(src_b),
                    dst: jroi_pkg::to_f24(dest_a), len: jroi_pkg::to_f24(len_tail)};
        r_done  = '{kind: jroi_pkg::KIND_COPY, word: '0, src: scan_bytes_reg,
                    dst: jroi_pkg::to_f24(dest_a), len: '0};
        r_pass  = '{kind: jroi_pkg::KIND_WORD, word: s_tdata, src: '0, dst: '0, len: '0};
        r_pend  = '{kind: jroi_pkg::KIND_COPY, word: '0, src: '0, dst: '0,
                    len: scan_bytes_reg};

        push_entry.done = last;
        if (pass_reg) begin
            push_entry.two = last;
            push_entry.r0  = r_pass;
            push_entry.r1  = r_pend;
        end else begin
            push_entry.two = (close && in_roi) || (in_roi && !close && tail);
            if (close) begin
                push_entry.r0 = r_close;
            end else if (in_roi) begin
                push_entry.r0 = r_word;
            end else if (tail) begin
                push_entry.r0 = r_tail;
            end else begin
                push_entry.r0 = r_done;
            end
            push_entry.r1 = (close && in_roi) ? r_word : r_tail;
        end
        push = accept && active && (pass_reg || any);

        // Advance block, MCU column and MCU row
        col_inc  = {1'b0, col_reg} + 14'd1;
        bc_next  = bc_reg + 24'd1;
        bim_next = bim_reg + 2'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (bim_reg == jroi_pkg::BIM_LAST) begin
            bim_next = '0;
            if (col_inc >= width_mcu_reg) begin
                col_next = '0;
                row_next = row_reg + 13'd1;
            end else begin
                col_next = col_inc[12:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg   <= '0;
            bim_reg  <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            run_reg  <= '0;
            src_reg  <= '0;
            dest_reg <= '0;
            prev_reg <= '0;
            open_reg <= 1'b0;
        end else if (accept && active) begin
            bc_reg  <= bc_next;
            bim_reg <= bim_next;
            col_reg <= col_next;
            row_reg <= row_next;
            run_reg <= absoff;
            if (!pass_reg) begin
                src_reg  <= src_next;
                dest_reg <= dest_next;
                prev_reg <= prev_next;
                open_reg <= open_next;
            end
        end
    end

endmodule

// File: hw/rtl/jroi_back.sv
// Back part: unpacks queue entries into single result words on the output register.
module jroi_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  jroi_pkg::entry_t       head,
    input  jroi_pkg::qstat_t       q_stat,
    input  jroi_pkg::crop_size_t   crop_size,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [135:0]           m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);

    logic              valid_reg, valid_next;
    logic              sel_reg, sel_next;
    jroi_pkg::result_t out_reg;
    logic              last_reg, done_reg;
    logic              load, is_end;
    jroi_pkg::result_t cur;

    // Pick the pending slot of the head entry
    always_comb begin
        load       = !q_stat.empty && (!valid_reg || m_tready);
        cur        = sel_reg ? head.r1 : head.r0;
        is_end     = sel_reg || !head.two;
        pop        = load && is_end;
        sel_next   = load ? !is_end : sel_reg;
        valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    // Hold the word until taken
    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg  <= cur;
            last_reg <= is_end;
            done_reg <= is_end && head.done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {done_reg, out_reg.kind};
    assign m_tdata  = {crop_size.height, crop_size.width, out_reg.len, out_reg.dst,
                       out_reg.src, out_reg.word};

endmodule

// File: hw/rtl/jpeg_block_offset_roi_crop.sv
// Top level: ROI crop of a JPEG scan's packed block offset words.
// A word accepted at the input passes through the queue and then the output register.
// Throughput: one word per cycle when not stalled; a word with two results sends two words.
// The output register and the two-entry queue set the rate; queue full stalls input.
// Reset (aresetn low, synchronous) clears counters, offsets and queue; in the cycle after
// reset and after each configuration write the input is held while geometry settles.
`include "jpeg_block_offset_roi_crop_macros.svh"
module jpeg_block_offset_roi_crop (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [jroi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]                    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // packed_offset
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_packed_offset, copy_source, copy_dest, copy_length, cropped_width, cropped_height
    output logic [135:0]                   m_tdata,
    output logic [1:0]                     m_tuser,   // item_kind, crop_done
    output logic                           m_tlast    // run_last
);

    logic                 push, pop;
    jroi_pkg::entry_t     push_entry, head;
    jroi_pkg::qstat_t     q_stat;
    jroi_pkg::crop_size_t crop_size;

    jroi_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry),
        .crop_size  (crop_size)
    );

    jroi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    jroi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_stat    (q_stat),
        .crop_size (crop_size),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Checks on the front, queue and back coupling
    `JROI_ASSERT_IMPLY(a_no_push_full, aclk, aresetn, push, !q_stat.full, "push into full queue")
    `JROI_ASSERT_IMPLY(a_no_pop_empty, aclk, aresetn, pop, !q_stat.empty, "pop from empty queue")
    `JROI_ASSERT_IMPLY(a_done_is_last, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast, "done without last")
    `JROI_ASSERT_NEXT(a_cfg_settle, aclk, aresetn, cfg_valid && cfg_ready, !s_tready, "input taken while settling")

endmodule
